// ----- rtl/tlaw_pkg.sv -----
// ============================================================================
// tlaw_pkg
// Shared types and constants of the tiled/linear address walker.
// ============================================================================
package tlaw_pkg;

    // Fixed widths of the register file and of the result fields
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int BPP_W       = 3;
    localparam int COORD_W     = 16;
    localparam int PIX_CNT_W   = 24;
    localparam int OFFSET_W    = 26;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TO_TILES        = 3'd3;

    // Clamped configuration as seen by the walker and the offset pipeline
    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [BPP_W-1:0]   bpp;
        logic               to_tiles;
    } tlaw_cfg_t;

    // One classified pixel, passed from the walker to the offset pipeline
    typedef struct packed {
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [PIX_CNT_W-1:0] pix;
        logic                 last;
    } tlaw_entry_t;

endpackage

// ----- rtl/tlaw_front.sv -----
// ============================================================================
// tlaw_front
// Walk position counters: takes requests and emits pixel coordinates.
// ============================================================================
module tlaw_front #(
    parameter int TILE_SIZE = 32,
    parameter int DIM_W     = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlaw_pkg::tlaw_cfg_t  cfg,
    input  logic                 walk_clr,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 restart,
    output logic                 q_push,
    output tlaw_pkg::tlaw_entry_t q_data,
    input  logic                 q_full
);
    import tlaw_pkg::*;

    localparam int TIL_W = $clog2(TILE_SIZE);
    localparam int SUM_W = ((DIM_W > TIL_W) ? DIM_W : TIL_W) + 2;

    logic [TIL_W-1:0]     col_reg, col_next, col_cur;
    logic [TIL_W-1:0]     row_reg, row_next, row_cur;
    logic [DIM_W-1:0]     bx_reg, bx_next, bx_cur;
    logic [DIM_W-1:0]     by_reg, by_next, by_cur;
    logic [PIX_CNT_W-1:0] pix_reg, pix_next, pix_cur;
    logic [SUM_W-1:0]     x_s, y_s, bx_step, by_step, w_s, h_s, tile_s;
    logic                 col_ok, row_ok, tx_ok, ty_ok, last;
    logic                 fire;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;
    assign q_push   = fire;

    // Restart takes the walk back to the first pixel before it is produced
    assign col_cur = restart ? '0 : col_reg;
    assign row_cur = restart ? '0 : row_reg;
    assign bx_cur  = restart ? '0 : bx_reg;
    assign by_cur  = restart ? '0 : by_reg;
    assign pix_cur = restart ? '0 : pix_reg;

    assign w_s     = SUM_W'(cfg.width);
    assign h_s     = SUM_W'(cfg.height);
    assign tile_s  = SUM_W'(TILE_SIZE);
    assign x_s     = SUM_W'(bx_cur) + SUM_W'(col_cur);
    assign y_s     = SUM_W'(by_cur) + SUM_W'(row_cur);
    assign bx_step = SUM_W'(bx_cur) + tile_s;
    assign by_step = SUM_W'(by_cur) + tile_s;

    assign col_ok = (SUM_W'(col_cur) + SUM_W'(1) < tile_s) && (x_s + SUM_W'(1) < w_s);
    assign row_ok = (SUM_W'(row_cur) + SUM_W'(1) < tile_s) && (y_s + SUM_W'(1) < h_s);
    assign tx_ok  = bx_step < w_s;
    assign ty_ok  = by_step < h_s;

    always_comb
    begin
        col_next = '0;
        row_next = row_cur;
        bx_next  = bx_cur;
        by_next  = by_cur;
        pix_next = pix_cur + PIX_CNT_W'(1);
        last     = 1'b0;
        if (col_ok)
        begin
            col_next = col_cur + TIL_W'(1);
        end
        else if (row_ok)
        begin
            row_next = row_cur + TIL_W'(1);
        end
        else
        begin
            row_next = '0;
            if (tx_ok)
            begin
                bx_next = DIM_W'(bx_step);
            end
            else
            begin
                bx_next = '0;
                if (ty_ok)
                begin
                    by_next = DIM_W'(by_step);
                end
                else
                begin
                    // Final pixel: wrap the walk
                    by_next  = '0;
                    pix_next = '0;
                    last     = 1'b1;
                end
            end
        end
    end

    assign q_data.x    = COORD_W'(x_s);
    assign q_data.y    = COORD_W'(y_s);
    assign q_data.pix  = pix_cur;
    assign q_data.last = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            bx_reg  <= '0;
            by_reg  <= '0;
            pix_reg <= '0;
        end
        else if (walk_clr)
        begin
            col_reg <= '0;
            row_reg <= '0;
            bx_reg  <= '0;
            by_reg  <= '0;
            pix_reg <= '0;
        end
        else if (fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            bx_reg  <= bx_next;
            by_reg  <= by_next;
            pix_reg <= pix_next;
        end
    end

    a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last && !walk_clr |=> pix_reg == '0 && col_reg == '0 && row_reg == '0
                                      && bx_reg == '0 && by_reg == '0)
        else $error("walk did not wrap after final pixel");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !last && !walk_clr |=> pix_reg == $past(pix_cur) + PIX_CNT_W'(1))
        else $error("pixel count did not advance by one");

endmodule

// ----- rtl/tlaw_queue.sv -----
// ============================================================================
// tlaw_queue
// Short FIFO between the walker and the offset pipeline.
// ============================================================================
module tlaw_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tlaw_pkg::tlaw_entry_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  q_valid,
    output tlaw_pkg::tlaw_entry_t pop_data
);
    import tlaw_pkg::*;

    tlaw_entry_t       mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid  = count_reg != '0;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue read while empty");

endmodule

// ----- rtl/tlaw_back.sv -----
// ============================================================================
// tlaw_back
// Offset pipeline: turns pixel coordinates into byte offsets.
// ============================================================================
module tlaw_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tlaw_pkg::tlaw_cfg_t               cfg,
    input  logic                              q_valid,
    input  tlaw_pkg::tlaw_entry_t             q_data,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tlaw_pkg::OFFSET_W-1:0]     source_offset,
    output logic [tlaw_pkg::OFFSET_W-1:0]     dest_offset,
    output logic                              last_pixel
);
    import tlaw_pkg::*;

    localparam int YW_W  = 2 * COORD_W;
    localparam int LIN_W = YW_W + 1 + BPP_W;

    logic                 a_v_reg;
    logic [YW_W-1:0]      a_yw_reg;
    logic [COORD_W-1:0]   a_x_reg;
    logic [OFFSET_W-1:0]  a_til_reg;
    logic                 a_last_reg;
    logic                 o_v_reg;
    logic [OFFSET_W-1:0]  o_src_reg, o_dst_reg;
    logic                 o_last_reg;
    logic                 adv_o;
    logic [LIN_W-1:0]     lin_full;
    logic [OFFSET_W-1:0]  lin, til;

    // Advance the output stage when it is empty or being taken
    assign adv_o = !o_v_reg || out_ready;
    assign pop   = q_valid && (!a_v_reg || adv_o);

    assign til      = OFFSET_W'(q_data.pix) * OFFSET_W'(cfg.bpp);
    assign lin_full = (LIN_W'(a_yw_reg) + LIN_W'(a_x_reg)) * LIN_W'(cfg.bpp);
    assign lin      = OFFSET_W'(lin_full);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_yw_reg   <= YW_W'(q_data.y) * YW_W'(cfg.width);
            a_x_reg    <= q_data.x;
            a_til_reg  <= til;
            a_last_reg <= q_data.last;
        end
        if (adv_o && a_v_reg)
        begin
            o_src_reg  <= cfg.to_tiles ? lin : a_til_reg;
            o_dst_reg  <= cfg.to_tiles ? a_til_reg : lin;
            o_last_reg <= a_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                a_v_reg <= 1'b1;
            end
            else if (adv_o)
            begin
                a_v_reg <= 1'b0;
            end
            if (adv_o)
            begin
                o_v_reg <= a_v_reg;
            end
        end
    end

    assign out_valid     = o_v_reg;
    assign source_offset = o_src_reg;
    assign dest_offset   = o_dst_reg;
    assign last_pixel    = o_last_reg;

endmodule

// ----- rtl/tiled_to_linear_address_walker_unit.sv -----
// ============================================================================
// tiled_to_linear_address_walker_unit
// Address generator for copies between row-major and square-tiled images.
// ============================================================================
// Each request on the input channel (in_valid/in_ready, field restart) yields
// one result on the output channel (out_valid/out_ready): the source and
// destination byte offsets of one pixel copy and a flag on the final pixel.
// Tiles of TILE_SIZE x TILE_SIZE are walked row by row, pixels row by row
// inside each tile, and pixels beyond the image edges are skipped.
// The walker front end takes one request per cycle while the queue is not
// full and pushes the pixel coordinates into a four-entry queue; the offset
// pipeline behind it (one multiply stage, one scale-and-select stage) drains
// one entry per cycle while the receiver takes results. A result passes the
// queue, the multiply stage and the output register before it is valid.
// When the receiver stalls, the output register holds and the queue fills;
// in_ready drops once four requests are waiting.
// Reset: width 1, height 1, 4 bytes per pixel, tiles to row-major, walk at
// the first pixel. Any write to a known register also restarts the walk;
// write registers only while no request is outstanding.
// ============================================================================
module tiled_to_linear_address_walker_unit #(
    parameter int TILE_SIZE = 32,
    parameter int MAX_DIM   = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tlaw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlaw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tlaw_pkg::OFFSET_W-1:0]       source_offset,
    output logic [tlaw_pkg::OFFSET_W-1:0]       dest_offset,
    output logic                                last_pixel
);
    import tlaw_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [CFG_DATA_W-1:0] width_reg, height_reg;
    logic [BPP_W-1:0]      bpp_reg;
    logic                  to_tiles_reg;
    logic                  walk_clr;
    tlaw_cfg_t             cfg;
    logic                  q_push, q_full, q_pop, q_valid;
    tlaw_entry_t           q_in, q_out;

    // Map a zero dimension to one and saturate at MAX_DIM
    function automatic logic [COORD_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v == '0)
        begin
            r = COORD_W'(1);
        end
        else if (32'(v) > 32'(MAX_DIM))
        begin
            r = COORD_W'(MAX_DIM);
        end
        else
        begin
            r = COORD_W'(v);
        end
        return r;
    endfunction

    // Map zero bytes per pixel to one and saturate at four
    function automatic logic [BPP_W-1:0] clamp_bpp(input logic [BPP_W-1:0] v);
        logic [BPP_W-1:0] r;
        if (v == '0)
        begin
            r = BPP_W'(1);
        end
        else if (v > BPP_W'(4))
        begin
            r = BPP_W'(4);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Register file: a write to an unknown index is dropped and leaves the walk
    always_comb
    begin
        unique case (cfg_index)
            CFG_IMAGE_WIDTH,
            CFG_IMAGE_HEIGHT,
            CFG_BYTES_PER_PIXEL,
            CFG_TO_TILES:        walk_clr = cfg_we;
            default:             walk_clr = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= CFG_DATA_W'(1);
            height_reg   <= CFG_DATA_W'(1);
            bpp_reg      <= BPP_W'(4);
            to_tiles_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:     width_reg    <= cfg_data;
                CFG_IMAGE_HEIGHT:    height_reg   <= cfg_data;
                CFG_BYTES_PER_PIXEL: bpp_reg      <= cfg_data[BPP_W-1:0];
                CFG_TO_TILES:        to_tiles_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    assign cfg.width    = clamp_dim(width_reg);
    assign cfg.height   = clamp_dim(height_reg);
    assign cfg.bpp      = clamp_bpp(bpp_reg);
    assign cfg.to_tiles = to_tiles_reg;

    // Front end: walk the image and classify each request
    tlaw_front #(
        .TILE_SIZE (TILE_SIZE),
        .DIM_W     (DIM_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .walk_clr (walk_clr),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .restart  (restart),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_full   (q_full)
    );

    // Decouple the walker from a stalled receiver
    tlaw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .pop_data  (q_out)
    );

    // Back end: scale coordinates into byte offsets
    tlaw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_data        (q_out),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .source_offset (source_offset),
        .dest_offset   (dest_offset),
        .last_pixel    (last_pixel)
    );

endmodule
